@@ rtl/scwh_pkg.sv @@
// Shared types, constants and the sine-table entry function for the stereo chorus.
package scwh_pkg;

   localparam int unsigned STEP_W  = 12;
   localparam int unsigned DELAY_W = 19;
   localparam int unsigned COEF_W  = 17;
   localparam int unsigned PHASE_W = 24;
   localparam int unsigned SINE_W  = 17;  // signed, -32768..32768
   localparam int unsigned CSR_W   = 19;
   localparam int unsigned CSR_IDX_W = 3;
   localparam logic [COEF_W-1:0] Q16_ONE = COEF_W'(65536);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PHASE_STEP = 3'd0,
      CSR_BASE_DELAY = 3'd1,
      CSR_DEPTH      = 3'd2,
      CSR_HP_COEF    = 3'd3,
      CSR_MIX        = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'd0,
      ST_READ  = 3'd1,
      ST_WAIT  = 3'd2,
      ST_WET   = 3'd3,
      ST_HPF   = 3'd4,
      ST_MIX   = 3'd5,
      ST_SUM   = 3'd6,
      ST_DONE  = 3'd7
   } lane_state_type;

   typedef struct packed {
      logic [DELAY_W-1:0] base_delay;
      logic [DELAY_W-1:0] depth_delay;
      logic [COEF_W-1:0]  hp_coefficient;
      logic [COEF_W-1:0]  mix_level;
   } lane_cfg_type;

   // sin(2*pi*i/t) in Q1.15, folded Taylor series through x^9 with truncating steps.
   function automatic logic signed [SINE_W-1:0] sine_entry(input int unsigned i,
                                                          input int unsigned t);
      logic [63:0] h, x, x2, tt, s, q;
      logic        neg;
      h   = 64'(i) * 64'd2;
      neg = 1'b0;
      if (h >= 64'(t)) begin
         neg = 1'b1;
         h   = h - 64'(t);
      end
      if (64'd2 * h > 64'(t)) h = 64'(t) - h;
      x  = (64'd3373259426 * h) / 64'(t);
      x2 = (x * x) >> 30;
      tt = (64'd1 << 30) - x2 / 64'd72;
      tt = (64'd1 << 30) - ((x2 * tt) >> 30) / 64'd42;
      tt = (64'd1 << 30) - ((x2 * tt) >> 30) / 64'd20;
      tt = (64'd1 << 30) - ((x2 * tt) >> 30) / 64'd6;
      s  = (x * tt) >> 30;
      q  = (s + 64'd16384) >> 15;
      if (q > 64'd32768) q = 64'd32768;
      return neg ? -SINE_W'(q) : SINE_W'(q);
   endfunction

endpackage

@@ rtl/scwh_lane.sv @@
// One channel: delay line, LFO, interpolation, high-pass and dry/wet mix.
module scwh_lane import scwh_pkg::*; #(
   parameter int unsigned DELAY_DEPTH      = 2048,
   parameter int unsigned SAMPLE_WIDTH     = 24,
   parameter int unsigned SINE_TABLE_DEPTH = 256,
   parameter logic [PHASE_W-1:0] PHASE_INIT = '0
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic                           hold,
   input  logic signed [SAMPLE_WIDTH-1:0] sample,
   input  logic [$clog2(DELAY_DEPTH)-1:0] wp,
   input  logic [STEP_W-1:0]              phase_step,
   input  lane_cfg_type                   cfg,
   output logic                           done,
   output logic signed [SAMPLE_WIDTH-1:0] y,
   output logic                           clip
);
   localparam int unsigned AW   = $clog2(DELAY_DEPTH);
   localparam int unsigned SW   = $clog2(SINE_TABLE_DEPTH);
   localparam int unsigned RPW  = AW + 8;
   localparam int unsigned WETW = SAMPLE_WIDTH + 10;   // samples * 256, signed
   localparam int unsigned HPW  = WETW + 2;
   localparam int unsigned ACCW = SAMPLE_WIDTH + 27;
   localparam logic [RPW:0] CAP = (RPW+1)'((DELAY_DEPTH - 2) * 256);

   lane_state_type state_ff, state_in;

   logic [SAMPLE_WIDTH-1:0] line_mem [DELAY_DEPTH];
   logic                    wrap_ff;   // pointer has gone all the way round once
   logic [SAMPLE_WIDTH-1:0] rd0_ff, rd1_ff;
   logic                    v0_ff, v1_ff;

   logic [PHASE_W-1:0] phase_ff;
   logic signed [SAMPLE_WIDTH-1:0] x_ff;
   logic [AW-1:0] i0_ff, i1_ff;
   logic [7:0]    f_ff;
   logic signed [WETW-1:0] wet_ff;
   logic signed [HPW-1:0]  hp_ff, w_ff;
   logic signed [ACCW-1:0] dry_ff, wm_ff;
   logic signed [SAMPLE_WIDTH-1:0] y_ff;
   logic clip_ff;

   // constant sine table, built at elaboration
   logic signed [SINE_W-1:0] sine_rom [SINE_TABLE_DEPTH];
   for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_sine
      localparam logic signed [SINE_W-1:0] ENTRY = sine_entry(k, SINE_TABLE_DEPTH);
      assign sine_rom[k] = ENTRY;
   end

   // delay computation
   logic [SW-1:0] sidx;
   logic signed [SINE_W-1:0] s;
   logic [SINE_W:0] s1;
   logic [DELAY_W+SINE_W+1:0] prod;
   logic [RPW:0] d, rp_full;
   logic [RPW-1:0] rp;
   always_comb begin
      sidx    = phase_ff[PHASE_W-1 -: SW];
      s       = sine_rom[sidx];
      s1      = (SINE_W+1)'(s + SINE_W'(32768));
      prod    = (DELAY_W+SINE_W+2)'(cfg.depth_delay) * (DELAY_W+SINE_W+2)'(s1);
      d       = (RPW+1)'((DELAY_W+SINE_W+2)'(cfg.base_delay) + (prod >> 16));
      if ((DELAY_W+SINE_W+2)'(cfg.base_delay) + (prod >> 16) > (DELAY_W+SINE_W+2)'(CAP))
         d = CAP;
      rp_full = {1'b0, wp, 8'd0} + (RPW+1)'(DELAY_DEPTH * 256) - d;
      rp      = rp_full[RPW-1:0];
   end

   // dry gain 1 - 0.4*m; divide by five as multiply by 52429 / 2^18
   logic [COEF_W-1:0] c_sat, m_sat, g;
   logic [COEF_W:0]    g_num;
   logic [COEF_W+17:0] g_prod;
   always_comb begin
      c_sat  = (cfg.hp_coefficient > Q16_ONE) ? Q16_ONE : cfg.hp_coefficient;
      m_sat  = (cfg.mix_level > Q16_ONE) ? Q16_ONE : cfg.mix_level;
      g_num  = {m_sat, 1'b0} + (COEF_W+1)'(2);
      g_prod = (COEF_W+18)'(g_num) * (COEF_W+18)'(52429);
      g      = Q16_ONE - COEF_W'(g_prod >> 18);
   end

   logic signed [HPW+COEF_W:0] hp_prod;
   logic signed [HPW-1:0] hp_next;
   logic signed [ACCW-1:0] acc;
   logic signed [ACCW-25:0] yfull;
   always_comb begin
      hp_prod = (HPW+COEF_W+1)'(HPW'(wet_ff) - hp_ff) * $signed({1'b0, c_sat});
      hp_next = hp_ff + HPW'(hp_prod >>> 16);
      acc     = dry_ff + wm_ff + ACCW'(1 << 23);
      yfull   = acc[ACCW-1:24];
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (start) state_in = ST_READ;
         ST_READ: state_in = ST_WAIT;
         ST_WAIT: state_in = ST_WET;
         ST_WET:  state_in = ST_HPF;
         ST_HPF:  state_in = ST_MIX;
         ST_MIX:  state_in = ST_SUM;
         ST_SUM:  state_in = ST_DONE;
         ST_DONE: state_in = hold ? ST_DONE : ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wrap_ff  <= 1'b0;
         phase_ff <= PHASE_INIT;
         hp_ff    <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_IDLE && start && wp == AW'(DELAY_DEPTH - 1)) begin
            wrap_ff <= 1'b1;
         end
         if (state_ff == ST_READ) phase_ff <= phase_ff + PHASE_W'(phase_step);
         if (state_ff == ST_HPF) hp_ff <= hp_next;
      end
   end

   // memory: written at start, two taps read after; entries above wp unwritten until wrap
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start) line_mem[wp] <= sample;
      if (state_ff == ST_WAIT) begin
         rd0_ff <= line_mem[i0_ff];
         rd1_ff <= line_mem[i1_ff];
         v0_ff  <= wrap_ff | (i0_ff <= wp);
         v1_ff  <= wrap_ff | (i1_ff <= wp);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start) x_ff <= sample;
      if (state_ff == ST_READ) begin
         i0_ff <= rp[RPW-1:8];
         i1_ff <= rp[RPW-1:8] + AW'(1);
         f_ff  <= rp[7:0];
      end
      if (state_ff == ST_WET)
         wet_ff <= WETW'($signed(v0_ff ? rd0_ff : '0)) * $signed({2'b0, 9'(256) - 9'(f_ff)})
                 + WETW'($signed(v1_ff ? rd1_ff : '0)) * $signed({2'b0, 1'b0, f_ff});
      if (state_ff == ST_HPF) begin
         w_ff   <= HPW'(wet_ff) - hp_next;
         dry_ff <= ACCW'(x_ff) * $signed({1'b0, g, 8'd0});
      end
      if (state_ff == ST_MIX) wm_ff <= ACCW'(w_ff) * $signed({1'b0, m_sat});
      if (state_ff == ST_SUM) begin
         if (yfull > (ACCW-24)'((1 << (SAMPLE_WIDTH-1)) - 1)) begin
            y_ff <= {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
            clip_ff <= 1'b1;
         end else if (yfull < -(ACCW-24)'(1 << (SAMPLE_WIDTH-1))) begin
            y_ff <= {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
            clip_ff <= 1'b1;
         end else begin
            y_ff <= yfull[SAMPLE_WIDTH-1:0];
            clip_ff <= 1'b0;
         end
      end
   end

   assign done = (state_ff == ST_DONE);
   assign y    = y_ff;
   assign clip = clip_ff;
endmodule

@@ rtl/stereo_chorus_with_wet_highpass_top.sv @@
// Top level of the stereo chorus with high-passed wet path.
// Usage:
//  - req_ channel carries one stereo frame per transaction (valid/stall).
//  - rsp_ channel returns left_out, right_out and clipped per frame.
//  - csr_ port: write enable, register index 0..4, data; write only while idle.
// Timing: two lanes (left, right) run the same step sequence side by side,
//  each reading two taps from its own delay memory; the merge then loads the
//  result register and raises rsp_valid; only then can a new frame be accepted.
//  One frame is in the lanes at a time. The sequencer steps are tap address,
//  tap read, interpolate, filter, two multiplies and sum, then the merge.
// Reset (synchronous) sets phases and registers to defaults, clears filter
//  states, write pointer and delay-line wrap flags, so unwritten taps read zero.
// Stall: the result register holds until taken. A new frame may enter while a
//  result waits; if the lanes finish before it is taken they hold in their last
//  step. req_stall is high while a frame is in the lanes.
module stereo_chorus_with_wet_highpass_top import scwh_pkg::*; #(
   parameter int unsigned DELAY_DEPTH      = 2048,
   parameter int unsigned SAMPLE_WIDTH     = 24,
   parameter int unsigned SINE_TABLE_DEPTH = 256
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0] req_left_sample,
   input  logic signed [SAMPLE_WIDTH-1:0] req_right_sample,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_left_out,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_right_out,
   output logic                           rsp_clipped,
   input  logic                           csr_write,
   input  logic [CSR_IDX_W-1:0]           csr_index,
   input  logic [CSR_W-1:0]               csr_data
);
   localparam int unsigned AW = $clog2(DELAY_DEPTH);

   logic [STEP_W-1:0] step_ff;
   lane_cfg_type      cfg_ff;
   logic [AW-1:0]     wp_ff;
   logic              busy_ff, rsp_valid_ff;
   logic              start, hold, done_l, done_r, clip_l, clip_r;
   logic signed [SAMPLE_WIDTH-1:0] y_l, y_r, yl_ff, yr_ff;
   logic clip_ff;

   assign req_stall = busy_ff;
   assign start     = req_valid & ~req_stall;
   // result register still full and not taken this cycle
   assign hold      = rsp_valid_ff & rsp_stall;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_W'(35);
         cfg_ff.base_delay     <= DELAY_W'(110592);
         cfg_ff.depth_delay    <= DELAY_W'(30720);
         cfg_ff.hp_coefficient <= COEF_W'(3277);
         cfg_ff.mix_level      <= COEF_W'(32768);
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_PHASE_STEP: step_ff <= csr_data[STEP_W-1:0];
            CSR_BASE_DELAY: cfg_ff.base_delay <= csr_data[DELAY_W-1:0];
            CSR_DEPTH:      cfg_ff.depth_delay <= csr_data[DELAY_W-1:0];
            CSR_HP_COEF:    cfg_ff.hp_coefficient <= csr_data[COEF_W-1:0];
            CSR_MIX:        cfg_ff.mix_level <= csr_data[COEF_W-1:0];
            default: ;
         endcase
      end
   end

   scwh_lane #(.DELAY_DEPTH(DELAY_DEPTH), .SAMPLE_WIDTH(SAMPLE_WIDTH),
               .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH), .PHASE_INIT('0)) u_left (
      .clock, .reset, .start, .hold, .sample(req_left_sample), .wp(wp_ff),
      .phase_step(step_ff), .cfg(cfg_ff), .done(done_l), .y(y_l), .clip(clip_l));

   scwh_lane #(.DELAY_DEPTH(DELAY_DEPTH), .SAMPLE_WIDTH(SAMPLE_WIDTH),
               .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
               .PHASE_INIT(PHASE_W'(4194304))) u_right (
      .clock, .reset, .start, .hold, .sample(req_right_sample), .wp(wp_ff),
      .phase_step(step_ff), .cfg(cfg_ff), .done(done_r), .y(y_r), .clip(clip_r));

   // merge: both lanes finish together; join into the result register once free
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         wp_ff        <= '0;
      end else begin
         if (start) busy_ff <= 1'b1;
         if (done_l & done_r & ~hold) begin
            busy_ff      <= 1'b0;
            rsp_valid_ff <= 1'b1;
            wp_ff        <= wp_ff + AW'(1);
         end else if (rsp_valid_ff & ~rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (done_l & done_r & ~hold) begin
         yl_ff   <= y_l;
         yr_ff   <= y_r;
         clip_ff <= clip_l | clip_r;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_left_out  = yl_ff;
   assign rsp_right_out = yr_ff;
   assign rsp_clipped   = clip_ff;
endmodule

@@ bench/tb_stereo_chorus_with_wet_highpass_top.sv @@
// Self-checking bench for the stereo chorus with high-passed wet path.
`timescale 1ns / 1ps
module tb_stereo_chorus_with_wet_highpass_top import scwh_pkg::*; ();

   localparam int LINE_LEN   = 2048;
   localparam int TBL_LEN    = 256;
   localparam int CYCLE_CAP  = 1000000;

   typedef struct {
      logic signed [23:0] left;
      logic signed [23:0] right;
      logic               clip;
   } frame_out_type;

   // Scoreboard: its own chorus model and a queue of expected frames.
   class chorus_scoreboard;
      longint left_line[LINE_LEN];
      longint right_line[LINE_LEN];
      int unsigned wr_ptr;
      int unsigned phase_l, phase_r;
      longint hp_l, hp_r;
      int unsigned step_r, base_r, span_r, coef_r, mix_r;
      longint sine_tbl[TBL_LEN];
      frame_out_type pending_frames[$];
      int mismatches;

      function new();
         for (int i = 0; i < TBL_LEN; i++) sine_tbl[i] = sine_val(i);
         mismatches = 0;
         clear();
      endfunction

      // Folded Taylor series through x^9, Q1.15.
      function longint sine_val(int unsigned i);
         longint unsigned h, x, x2, t, s, q;
         bit neg;
         h = 64'(i) * 2;
         neg = 0;
         if (h >= TBL_LEN) begin
            neg = 1;
            h -= TBL_LEN;
         end
         if (2 * h > TBL_LEN) h = TBL_LEN - h;
         x  = (64'd3373259426 * h) / TBL_LEN;
         x2 = (x * x) >> 30;
         t  = (64'd1 << 30) - x2 / 72;
         t  = (64'd1 << 30) - ((x2 * t) >> 30) / 42;
         t  = (64'd1 << 30) - ((x2 * t) >> 30) / 20;
         t  = (64'd1 << 30) - ((x2 * t) >> 30) / 6;
         s  = (x * t) >> 30;
         q  = (s + 16384) >> 15;
         if (q > 32768) q = 32768;
         return neg ? -longint'(q) : longint'(q);
      endfunction

      function void clear();
         foreach (left_line[i]) begin
            left_line[i] = 0;
            right_line[i] = 0;
         end
         wr_ptr = 0; phase_l = 0; phase_r = 4194304; hp_l = 0; hp_r = 0;
         step_r = 35; base_r = 110592; span_r = 30720; coef_r = 3277; mix_r = 32768;
      endfunction

      function void set_reg(int idx, int unsigned val);
         case (idx)
            CSR_PHASE_STEP: step_r = val & 'hFFF;
            CSR_BASE_DELAY: base_r = val & 'h7FFFF;
            CSR_DEPTH:      span_r = val & 'h7FFFF;
            CSR_HP_COEF:    coef_r = val & 'h1FFFF;
            CSR_MIX:        mix_r  = val & 'h1FFFF;
            default: ;
         endcase
      endfunction

      function longint fshift(longint v, int s);
         return v >>> s;
      endfunction

      function longint chorus_lane(ref longint line[LINE_LEN], ref int unsigned ph,
                                   ref longint hp, input longint x, ref bit clip);
         longint s, d, rp, wet, c, m, g, acc, y, w;
         int unsigned i0, i1, f;
         line[wr_ptr] = x;
         s = sine_tbl[(longint'(ph) * TBL_LEN) >> 24];
         ph = (ph + step_r) & 'hFFFFFF;
         d = longint'(base_r) + ((longint'(span_r) * (s + 32768)) >>> 16);
         if (d > (LINE_LEN - 2) * 256) d = (LINE_LEN - 2) * 256;
         rp = ((longint'(wr_ptr) << 8) + LINE_LEN * 256 - d) % (LINE_LEN * 256);
         i0 = rp >> 8;
         f = rp & 255;
         i1 = (i0 + 1) % LINE_LEN;
         wet = line[i0] * (256 - f) + line[i1] * f;
         c = coef_r > 65536 ? 65536 : coef_r;
         hp += fshift(c * (wet - hp), 16);
         w = wet - hp;
         m = mix_r > 65536 ? 65536 : mix_r;
         g = 65536 - (2 * m + 2) / 5;
         acc = x * g * 256 + w * m + (longint'(1) << 23);
         y = fshift(acc, 24);
         if (y > 8388607) begin
            y = 8388607; clip = 1;
         end else if (y < -8388608) begin
            y = -8388608; clip = 1;
         end
         return y;
      endfunction

      function void note_frame(logic signed [23:0] l, logic signed [23:0] r);
         frame_out_type e;
         bit clip;
         clip = 0;
         e.left  = 24'(chorus_lane(left_line, phase_l, hp_l, longint'(l), clip));
         e.right = 24'(chorus_lane(right_line, phase_r, hp_r, longint'(r), clip));
         e.clip  = clip;
         wr_ptr = (wr_ptr + 1) % LINE_LEN;
         pending_frames.push_back(e);
      endfunction

      function void check_frame(frame_out_type got);
         frame_out_type e;
         if (pending_frames.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected output frame l=%0d r=%0d",
                                           got.left, got.right);
            return;
         end
         e = pending_frames.pop_front();
         if (got.left !== e.left || got.right !== e.right || got.clip !== e.clip) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: exp l=%0d r=%0d c=%0d got l=%0d r=%0d c=%0d",
                        e.left, e.right, e.clip, got.left, got.right, got.clip);
         end
      endfunction
   endclass

   logic clock, reset;
   logic req_valid, req_stall, rsp_valid, rsp_stall, rsp_clipped;
   logic signed [23:0] req_left_sample, req_right_sample, rsp_left_out, rsp_right_out;
   logic csr_write;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0] csr_data;

   chorus_scoreboard sb;
   int cycles;
   bit sink_idle_off;   // stretches with no receiver stalls
   bit src_idle_off;

   stereo_chorus_with_wet_highpass_top i_dut (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // Watchdog on total run length.
   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_CAP) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   // Result side: random stall per transaction, checked on acceptance.
   initial begin
      frame_out_type got;
      int gap;
      rsp_stall = 1;
      @(posedge clock iff !reset);
      forever begin
         gap = sink_idle_off ? 0 : $urandom_range(0, 13);
         if (gap != 0) begin
            rsp_stall <= 1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 0;
         @(posedge clock iff rsp_valid);
         got.left = rsp_left_out;
         got.right = rsp_right_out;
         got.clip = rsp_clipped;
         sb.check_frame(got);
      end
   end

   task automatic send_frame(logic signed [23:0] l, logic signed [23:0] r);
      int gap;
      gap = src_idle_off ? 0 : $urandom_range(0, 13);
      if (gap != 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_left_sample <= l;
      req_right_sample <= r;
      @(posedge clock iff !req_stall);
      sb.note_frame(l, r);
   endtask

   // Lower valid once the current transaction is done, then wait for drain.
   task automatic drain();
      req_valid <= 0;
      while (sb.pending_frames.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, int unsigned val);
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= CSR_W'(val);
      @(posedge clock);
      csr_write <= 0;
      sb.set_reg(idx, val);
      @(posedge clock);
   endtask

   function automatic logic signed [23:0] rand_sample();
      case ($urandom_range(0, 5))
         0: return 24'sh7FFFFF;
         1: return -24'sh800000;
         default: return 24'($urandom);
      endcase
   endfunction

   initial begin
      sb = new();
      reset = 1;
      req_valid = 0;
      req_left_sample = 0;
      req_right_sample = 0;
      csr_write = 0;
      csr_index = 0;
      csr_data = 0;
      sink_idle_off = 0;
      src_idle_off = 0;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: defaults, extremes of the samples, silence.
      send_frame(24'sh7FFFFF, -24'sh800000);
      send_frame(-24'sh800000, 24'sh7FFFFF);
      send_frame(0, 0);
      send_frame(24'sh555555, 24'shAAAAAA);
      drain();

      // Zero delay, mix and coefficient at one: tap reads the new sample.
      write_reg(CSR_BASE_DELAY, 0);
      write_reg(CSR_DEPTH, 0);
      write_reg(CSR_MIX, 65536);
      write_reg(CSR_HP_COEF, 65536);
      for (int i = 0; i < 4; i++) send_frame(24'sh7FFFFF, -24'sh800000);
      drain();

      // Over-long delay capped; coefficient and mix above one; bad index ignored.
      write_reg(CSR_BASE_DELAY, 524032);
      write_reg(CSR_DEPTH, 524032);
      write_reg(CSR_HP_COEF, 131071);
      write_reg(CSR_MIX, 131071);
      write_reg(CSR_PHASE_STEP, 4095);
      csr_write <= 1;
      csr_index <= 3'd7;
      csr_data <= '1;
      @(posedge clock);
      csr_write <= 0;
      for (int i = 0; i < 6; i++) send_frame(rand_sample(), rand_sample());
      drain();

      // Random phases, each with fresh settings; short delays so echoes appear.
      for (int ph = 0; ph < 13; ph++) begin
         write_reg(CSR_PHASE_STEP, ph == 0 ? 0 : $urandom_range(0, 4095));
         write_reg(CSR_BASE_DELAY, ph == 1 ? 0 : $urandom_range(0, 40 * 256));
         write_reg(CSR_DEPTH, ph == 2 ? 524032 : $urandom_range(0, 60 * 256));
         write_reg(CSR_HP_COEF, ph == 3 ? 0 : $urandom_range(0, 70000));
         write_reg(CSR_MIX, ph == 4 ? 0 : $urandom_range(0, 70000));
         sink_idle_off = (ph % 4) == 1;
         src_idle_off = (ph % 3) == 2;
         for (int i = 0; i < 100; i++) send_frame(rand_sample(), rand_sample());
         drain();
      end

      if (sb.mismatches == 0 && sb.pending_frames.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
